// ----- hdl/mks_pkg.sv -----
// ----------------------------------------------------------------------------
// mks_pkg
// Shared constants, symbol table and control types of the Morse keyer.
// ----------------------------------------------------------------------------
package mks_pkg;

  localparam int MSG_BUF_DEF = 100;

  localparam logic [15:0] DOT_RST  = 16'd100;
  localparam logic [15:0] DASH_RST = 16'd300;
  localparam logic [15:0] EGAP_RST = 16'd100;
  localparam logic [15:0] CGAP_RST = 16'd300;

  // register indexes (word address)
  localparam logic [1:0] REG_DOT  = 2'd0;
  localparam logic [1:0] REG_DASH = 2'd1;
  localparam logic [1:0] REG_EGAP = 2'd2;
  localparam logic [1:0] REG_CGAP = 2'd3;

  // segment kinds
  localparam logic [1:0] SEG_ELEM  = 2'd0;
  localparam logic [1:0] SEG_TRAIL = 2'd1;
  localparam logic [1:0] SEG_EGAP  = 2'd2;
  localparam logic [1:0] SEG_CGAP  = 2'd3;

  // trailer is dot-dash three times: elements 0..5, odd ones are dashes
  localparam logic [2:0] TRAIL_LAST = 3'd5;

  localparam logic [7:0] CH_END = 8'h2E;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_Z   = 8'h5A;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  localparam int SYM_NUM = 36;

  typedef struct packed {
    logic [2:0] len;   // number of elements
    logic [4:0] bits;  // bit i = element i, 1 = dash
  } sym_t;

  // {len, bits}: digits 0-9 then letters A-Z
  localparam logic [7:0] SYM_TAB [0:SYM_NUM-1] = '{
    8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3, 8'hA7, 8'hAF,
    8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40, 8'h8E,
    8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62, 8'h60, 8'h21,
    8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83
  };

  function automatic sym_t sym_lookup(input logic [5:0] s);
    sym_t r;
    r = '0;
    if (s < 6'(SYM_NUM)) begin
      r = sym_t'(SYM_TAB[s]);
    end
    return r;
  endfunction

  typedef struct packed {
    logic       load;       // byte accepted
    logic       emit;       // write a segment into the output register
    logic [1:0] seg;
    logic       last;
    logic       elem_adv;
    logic       trail_adv;
  } mks_cmd_t;

  typedef struct packed {
    logic is_end;
    logic is_char;
    logic elem_last;
    logic trail_last;
    logic trail_due;
    logic out_free;
  } mks_stat_t;

endpackage

// ----- hdl/mks_if.sv -----
// ----------------------------------------------------------------------------
// mks_if
// Request channels of the Morse keyer: received bytes in, key segments out.
// ----------------------------------------------------------------------------
interface mks_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mks_out_if;
  logic        valid;
  logic        ready;
  logic        key_on;
  logic [15:0] duration;
  logic        last_segment;

  modport source (output valid, output key_on, output duration, output last_segment,
                  input ready);
  modport sink   (input valid, input key_on, input duration, input last_segment,
                  output ready);
endinterface

// ----- hdl/morse_keyer_from_serial_bytes_unit.sv -----
// ----------------------------------------------------------------------------
// morse_keyer_from_serial_bytes_unit
// Turns received bytes into Morse key segments, with APB timing registers.
// ----------------------------------------------------------------------------
// One byte is taken per request on in_ch and expands into key segments on
// out_ch, one segment per cycle from a single output register while out_ch
// does not stall: 2n+1 for a digit or capital letter of n elements, 12 for
// the end mark '.', 2n+1 + 12 (at most 23) for a character that fills the
// message, none for other bytes. The next byte waits for the last segment.
// The user must write the timing registers (16 bits, byte addresses 0, 4,
// 8, 12: dot, dash, element gap, character gap) over APB only while the
// block is idle; it does not enforce this. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module morse_keyer_from_serial_bytes_unit #(
  parameter int MESSAGE_BUFFER = mks_pkg::MSG_BUF_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mks_in_if.sink      in_ch,
  mks_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mks_pkg::*;

  logic [15:0] dot_r, dash_r, egap_r, cgap_r;
  logic        wr_en;
  logic [1:0]  reg_idx;
  mks_cmd_t    cmd;
  mks_stat_t   stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= DOT_RST;
      dash_r <= DASH_RST;
      egap_r <= EGAP_RST;
      cgap_r <= CGAP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DOT:  dot_r  <= pwdata[15:0];
        REG_DASH: dash_r <= pwdata[15:0];
        REG_EGAP: egap_r <= pwdata[15:0];
        REG_CGAP: cgap_r <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DOT:  prdata = {16'd0, dot_r};
      REG_DASH: prdata = {16'd0, dash_r};
      REG_EGAP: prdata = {16'd0, egap_r};
      REG_CGAP: prdata = {16'd0, cgap_r};
      default:  prdata = '0;
    endcase
  end

  mks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mks_dp #(
    .MESSAGE_BUFFER (MESSAGE_BUFFER)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_byte      (in_ch.rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .dot_len      (dot_r),
    .dash_len     (dash_r),
    .elem_gap     (egap_r),
    .char_gap     (cgap_r),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .key_on       (out_ch.key_on),
    .duration     (out_ch.duration),
    .last_segment (out_ch.last_segment)
  );

endmodule

// ----- hdl/mks_ctrl.sv -----
// ----------------------------------------------------------------------------
// mks_ctrl
// Segment sequencer: walks a character's elements, its gap and the trailer.
// ----------------------------------------------------------------------------
module mks_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mks_pkg::mks_stat_t stat,
  output mks_pkg::mks_cmd_t  cmd
);
  import mks_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ON   = 3'd1;
  localparam logic [2:0] S_GAP  = 3'd2;
  localparam logic [2:0] S_CGAP = 3'd3;
  localparam logic [2:0] S_TON  = 3'd4;
  localparam logic [2:0] S_TGAP = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       emit;

  assign in_ready = (state_r == S_IDLE);
  assign emit     = (state_r != S_IDLE) && stat.out_free;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.load      = in_valid && in_ready;
    cmd.emit      = emit;
    cmd.seg       = SEG_EGAP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.is_end) begin
            state_nxt = S_TON;
          end else if (stat.is_char) begin
            state_nxt = S_ON;
          end
        end
      end
      S_ON: begin
        cmd.seg = SEG_ELEM;
        if (emit) state_nxt = S_GAP;
      end
      S_GAP: begin
        cmd.seg      = SEG_EGAP;
        cmd.elem_adv = emit && !stat.elem_last;
        if (emit) state_nxt = stat.elem_last ? S_CGAP : S_ON;
      end
      S_CGAP: begin
        cmd.seg  = SEG_CGAP;
        cmd.last = !stat.trail_due;
        if (emit) state_nxt = stat.trail_due ? S_TON : S_IDLE;
      end
      S_TON: begin
        cmd.seg = SEG_TRAIL;
        if (emit) state_nxt = S_TGAP;
      end
      S_TGAP: begin
        cmd.seg       = SEG_EGAP;
        cmd.last      = stat.trail_last;
        cmd.trail_adv = emit && !stat.trail_last;
        if (emit) state_nxt = stat.trail_last ? S_IDLE : S_TON;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/mks_dp.sv -----
// ----------------------------------------------------------------------------
// mks_dp
// Keyer datapath: byte decode, element pattern, message counter and the
// output segment register.
// ----------------------------------------------------------------------------
module mks_dp #(
  parameter int MESSAGE_BUFFER = mks_pkg::MSG_BUF_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         rx_byte,
  input  mks_pkg::mks_cmd_t  cmd,
  output mks_pkg::mks_stat_t stat,
  input  logic [15:0]        dot_len,
  input  logic [15:0]        dash_len,
  input  logic [15:0]        elem_gap,
  input  logic [15:0]        char_gap,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               key_on,
  output logic [15:0]        duration,
  output logic               last_segment
);
  import mks_pkg::*;

  localparam int CNT_W = (MESSAGE_BUFFER > 2) ? $clog2(MESSAGE_BUFFER) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MESSAGE_BUFFER - 1);

  logic             is_digit, is_letter;
  logic [5:0]       sym_idx;
  sym_t             sym;
  logic [CNT_W-1:0] cnt_r, cnt_inc;
  logic [4:0]       pat_r;
  logic [2:0]       rem_r;
  logic [2:0]       tidx_r;
  logic             due_r;
  logic             out_valid_r;
  logic             key_r, last_r;
  logic [15:0]      dur_r, dur_nxt;

  assign is_digit  = (rx_byte >= CH_0) && (rx_byte <= CH_9);
  assign is_letter = (rx_byte >= CH_A) && (rx_byte <= CH_Z);
  assign sym_idx   = is_digit ? 6'(rx_byte - CH_0) : 6'(rx_byte - CH_A + LETTER_OFS);
  assign sym       = sym_lookup(sym_idx);
  assign cnt_inc   = cnt_r + 1'b1;

  assign stat.is_end     = (rx_byte == CH_END);
  assign stat.is_char    = is_digit || is_letter;
  assign stat.elem_last  = (rem_r == 3'd0);
  assign stat.trail_last = (tidx_r == TRAIL_LAST);
  assign stat.trail_due  = due_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    case (cmd.seg)
      SEG_ELEM:  dur_nxt = pat_r[0] ? dash_len : dot_len;
      SEG_TRAIL: dur_nxt = tidx_r[0] ? dash_len : dot_len;
      SEG_EGAP:  dur_nxt = elem_gap;
      default:   dur_nxt = char_gap;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      due_r       <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (stat.is_end) begin
          cnt_r <= '0;
          due_r <= 1'b0;
        end else if (stat.is_char) begin
          cnt_r <= (cnt_inc == CNT_LAST) ? '0 : cnt_inc;
          due_r <= (cnt_inc == CNT_LAST);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pat_r  <= sym.bits;
      rem_r  <= sym.len - 3'd1;
      tidx_r <= '0;
    end else begin
      if (cmd.elem_adv) begin
        pat_r <= pat_r >> 1;
        rem_r <= rem_r - 3'd1;
      end
      if (cmd.trail_adv) begin
        tidx_r <= tidx_r + 3'd1;
      end
    end
    if (cmd.emit) begin
      key_r  <= (cmd.seg == SEG_ELEM) || (cmd.seg == SEG_TRAIL);
      dur_r  <= dur_nxt;
      last_r <= cmd.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign key_on       = key_r;
  assign duration     = dur_r;
  assign last_segment = last_r;

endmodule

// ----- dv/mks_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mks_tb_pkg
// Key segment prediction and checking for the Morse keyer testbench: each
// accepted byte is expanded into the segments it should produce, and each
// segment leaving the block is matched against the oldest one still due.
// ----------------------------------------------------------------------------
package mks_tb_pkg;
  import mks_pkg::*;

  localparam int MSG_LEN    = MSG_BUF_DEF;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic        key_on;
    logic [15:0] duration;
    logic        last_segment;
  } key_seg_t;

  class keyer_scoreboard;
    logic [15:0] dot_len;
    logic [15:0] dash_len;
    logic [15:0] elem_gap;
    logic [15:0] char_gap;
    logic [6:0]  char_count;
    key_seg_t    due_segments[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned chars;
    int unsigned ignored;
    int unsigned end_marks;
    int unsigned forced_ends;

    function new();
      dot_len    = DOT_RST;
      dash_len   = DASH_RST;
      elem_gap   = EGAP_RST;
      char_gap   = CGAP_RST;
      char_count = '0;
    endfunction

    function void set_timing(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_DOT:  dot_len  = value;
        REG_DASH: dash_len = value;
        REG_EGAP: elem_gap = value;
        REG_CGAP: char_gap = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_segments.size();
    endfunction

    // ITU patterns, digits first, then letters
    function string morse_pattern(int sym);
      case (sym)
        0:  return "-----";
        1:  return ".----";
        2:  return "..---";
        3:  return "...--";
        4:  return "....-";
        5:  return ".....";
        6:  return "-....";
        7:  return "--...";
        8:  return "---..";
        9:  return "----.";
        10: return ".-";
        11: return "-...";
        12: return "-.-.";
        13: return "-..";
        14: return ".";
        15: return "..-.";
        16: return "--.";
        17: return "....";
        18: return "..";
        19: return ".---";
        20: return "-.-";
        21: return ".-..";
        22: return "--";
        23: return "-.";
        24: return "---";
        25: return ".--.";
        26: return "--.-";
        27: return ".-.";
        28: return "...";
        29: return "-";
        30: return "..-";
        31: return "...-";
        32: return ".--";
        33: return "-..-";
        34: return "-.--";
        35: return "--..";
        default: return "";
      endcase
    endfunction

    function void add_seg(logic on, logic [15:0] dur);
      key_seg_t s;
      s.key_on       = on;
      s.duration     = dur;
      s.last_segment = 1'b0;
      due_segments.push_back(s);
    endfunction

    // dot-dash three times, element gap after each, no character gap
    function void add_trailer();
      for (int k = 0; k < 3; k++) begin
        add_seg(1'b1, dot_len);
        add_seg(1'b0, elem_gap);
        add_seg(1'b1, dash_len);
        add_seg(1'b0, elem_gap);
      end
    endfunction

    function void expand_byte(logic [7:0] b);
      string    pat;
      key_seg_t s;
      if (b == CH_END) begin
        add_trailer();
        char_count = '0;
        end_marks++;
      end else begin
        if (b >= CH_0 && b <= CH_9) begin
          pat = morse_pattern(int'(b - CH_0));
        end else if (b >= CH_A && b <= CH_Z) begin
          pat = morse_pattern(int'(b - CH_A + LETTER_OFS));
        end else begin
          ignored++;
          return;
        end
        for (int i = 0; i < pat.len(); i++) begin
          add_seg(1'b1, (pat[i] == "-") ? dash_len : dot_len);
          add_seg(1'b0, elem_gap);
        end
        add_seg(1'b0, char_gap);
        chars++;
        char_count = char_count + 7'd1;
        // message full: close it as if an end mark had come
        if (char_count >= 7'(MSG_LEN - 1)) begin
          add_trailer();
          char_count = '0;
          forced_ends++;
        end
      end
      s = due_segments.pop_back();
      s.last_segment = 1'b1;
      due_segments.push_back(s);
    endfunction

    task report_mismatch(string msg);
      if (errors < PRINT_CAP) $display("mismatch at segment %0d: %s", checked, msg);
      errors++;
    endtask

    task match_segment(logic on, logic [15:0] dur, logic last);
      key_seg_t want;
      if (due_segments.size() == 0) begin
        report_mismatch($sformatf("unrequested segment key_on=%0b duration=%0d last=%0b",
                                  on, dur, last));
        return;
      end
      want = due_segments.pop_front();
      if (on !== want.key_on)
        report_mismatch($sformatf("key_on %0b, wanted %0b", on, want.key_on));
      if (dur !== want.duration)
        report_mismatch($sformatf("duration %0d, wanted %0d", dur, want.duration));
      if (last !== want.last_segment)
        report_mismatch($sformatf("last_segment %0b, wanted %0b", last, want.last_segment));
      checked++;
    endtask
  endclass

endpackage

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Byte-in, key-segment-out check of the Morse keyer.
// Directed bytes at reset timing, then random messages under several timing
// settings and handshake pressure; every segment is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import mks_pkg::*;
  import mks_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 30;
  localparam int LONG_MESSAGE  = 105;

  // extremes of the byte, symbol boundaries, ignored neighbors, end marks
  localparam logic [7:0] DIRECTED_BYTES [18] = '{
    CH_0, CH_9, CH_A, CH_Z, 8'h45, 8'h54, CH_END, 8'h00, 8'hFF,
    8'h61, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h51, 8'h59, CH_END, 8'h2D
  };

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        take_ready = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned take_stall_pct = 0;
  int unsigned cycles         = 0;
  int unsigned keyed_sent     = 0;
  int unsigned timing_sets    = 1;

  keyer_scoreboard sb;

  mks_in_if  in_ch();
  mks_out_if out_ch();

  assign out_ch.ready = take_ready;

  morse_keyer_from_serial_bytes_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    take_ready <= ($urandom_range(99) >= take_stall_pct);
  end

  // segments leaving in this cycle belong to earlier bytes: check first
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.match_segment(out_ch.key_on, out_ch.duration, out_ch.last_segment);
      if (in_ch.valid && in_ch.ready)
        sb.expand_byte(in_ch.rx_byte);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL morse_keyer_from_serial_bytes_unit");
      $finish;
    end
  end

  function automatic logic is_keyed(logic [7:0] b);
    return b == CH_END || (b >= CH_0 && b <= CH_9) || (b >= CH_A && b <= CH_Z);
  endfunction

  function automatic logic [7:0] symbol_byte(int unsigned sym);
    return (sym < 10) ? CH_0 + 8'(sym) : CH_A + 8'(sym) - LETTER_OFS;
  endfunction

  // valid only drops while idling, so back-to-back requests keep it high
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (is_keyed(b)) keyed_sent++;
  endtask

  task automatic drain_segments();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_timing(idx, value);
  endtask

  task automatic load_timing(input logic [15:0] dot, dash, egap, cgap);
    drain_segments();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_DOT, dot);
    apb_write(REG_DASH, dash);
    apb_write(REG_EGAP, egap);
    apb_write(REG_CGAP, cgap);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    timing_sets++;
  endtask

  // mostly symbols, some stray bytes; unclosed messages run on
  task automatic send_message(input int n_chars, input bit closed);
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(99) < 12) send_byte(8'($urandom));
      else send_byte(symbol_byte($urandom_range(35)));
    end
    if (closed) send_byte(CH_END);
  endtask

  initial begin
    int unsigned target;
    bit          paused;
    sb = new();
    paused        = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: load_timing(16'd1, 16'd1, 16'd1, 16'd1);
        1: load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_timing(16'd0, 16'($urandom), 16'($urandom), 16'd0);
        default: load_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      send_idle_pct  = (p == 1) ? 52 : (p == 3) ? 31 : 0;
      take_stall_pct = (p == 2) ? 52 : (p == 3) ? 31 : 0;
      target = keyed_sent + PHASE_ITEMS;
      // no end mark for a while: the character count must close the message
      if (p == 1) begin
        for (int i = 0; i < LONG_MESSAGE; i++) send_byte(symbol_byte($urandom_range(35)));
      end
      while (keyed_sent < target) begin
        if (p == 2 && !paused && keyed_sent + PHASE_ITEMS / 2 >= target) begin
          drain_segments();
          paused = 1'b1;
        end
        send_message($urandom_range(12), $urandom_range(9) != 0);
      end
    end

    drain_segments();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d characters, %0d stray bytes, %0d segments checked",
             sb.chars, sb.ignored, sb.checked);
    $display("with %0d end marks, %0d full-message closes, %0d timing settings",
             sb.end_marks, sb.forced_ends, timing_sets);
    if (sb.errors == 0) begin
      $display("PASS morse_keyer_from_serial_bytes_unit");
    end else begin
      $display("FAIL morse_keyer_from_serial_bytes_unit");
    end
    $finish;
  end

endmodule
